>>> src/mld_pkg.sv
package mld_pkg;

  localparam int NUM_INPUTS  = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int PIN_W       = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int IDX_W       = 3;
  localparam int LEVELS_W    = 8;
  localparam int DELAY_W     = 16;
  localparam int GROUP_PINS  = 4;
  localparam int GROUP_W     = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam logic [LEVELS_W-1:0]    ENABLE_RESET = 8'hFF;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAYS_LOW  = 2'd0,
    CFG_DELAYS_HIGH = 2'd1,
    CFG_ENABLE_MASK = 2'd2,
    CFG_INVERT      = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_RESYNC = 1'b1
  } op_t;

  typedef struct packed {
    logic                   resync;
    logic                   level;
    logic                   stable;
    logic                   known;
    logic                   enable;
    logic [COUNT_WIDTH-1:0] count;
    logic [DELAY_W-1:0]     delay;
  } pin_req_t;

  typedef struct packed {
    logic                   accept;
    logic [COUNT_WIDTH-1:0] count;
  } pin_res_t;

endpackage

>>> src/mld_if.sv
interface mld_in_if;
  import mld_pkg::*;
  logic                valid;
  logic                ready;
  logic                op;
  logic [LEVELS_W-1:0] pin_levels;

  modport source(output valid, output op, output pin_levels, input ready);
  modport sink(input valid, input op, input pin_levels, output ready);
endinterface

interface mld_out_if;
  import mld_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    input_index;
  logic                reported_level;
  logic [LEVELS_W-1:0] stable_levels;
  logic                last_report;

  modport source(output valid, output input_index, output reported_level,
                 output stable_levels, output last_report, input ready);
  modport sink(input valid, input input_index, input reported_level,
               input stable_levels, input last_report, output ready);
endinterface

>>> src/mld_count_unit.sv
module mld_count_unit (
  input  mld_pkg::pin_req_t req,
  output mld_pkg::pin_res_t res
);
  import mld_pkg::*;

  logic [COUNT_WIDTH-1:0] up;

  always_comb begin
    up = (req.count == COUNT_MAX) ? req.count : req.count + 1'b1;
    res.accept = 1'b0;
    res.count  = req.count;
    priority if (req.resync) begin
      res.accept = 1'b1;
      res.count  = '0;
    end else if (req.known && (req.level == req.stable)) begin
      res.count = (req.count != '0) ? req.count - 1'b1 : req.count;
    end else begin
      res.accept = req.enable && (DELAY_W'(up) >= req.delay);
      res.count  = res.accept ? '0 : up;
    end
  end
endmodule

>>> src/multi_input_leaky_debouncer.sv
// Eight-input leaky debouncer.
// in_ch carries one item per sample tick (op = 0) or resync (op = 1) with
// the raw levels of all pins. out_ch carries one item per accepted pin,
// lowest pin first, with last_report set on the final one of an input item.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are to be made only
// while idle; the block itself does not enforce this. After an input item
// is accepted, one shared counter unit visits the pins one per cycle. Then
// the reports are loaded into the output register one at a time, and
// in_ch.ready rises again after the last one is loaded.
// A tick with no accepted pin gives no output item.
// The output register holds its item while out_ch.ready is low; the report
// walk waits for it, and in_ch.ready stays low until the last report of the
// item has been loaded.
// Reset clears all pin state (levels unknown, counters zero), the delays,
// and sets every delay enable bit; no output item is pending after reset.
module multi_input_leaky_debouncer (
  input  logic                       clk,
  input  logic                       rst,
  mld_in_if.sink                     in_ch,
  mld_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [mld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mld_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mld_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_EMIT
  } state_t;

  state_t state;

  logic [GROUP_W-1:0]  delays_low;
  logic [GROUP_W-1:0]  delays_high;
  logic [LEVELS_W-1:0] enable_mask;
  logic                invert;

  logic                   stable_level [NUM_INPUTS];
  logic                   level_known  [NUM_INPUTS];
  logic [COUNT_WIDTH-1:0] change_count [NUM_INPUTS];

  logic                  op_r;
  logic [LEVELS_W-1:0]   pins_r;
  logic [PIN_W-1:0]      pin_ctr;
  logic [NUM_INPUTS-1:0] acc_mask;

  logic [DELAY_W-1:0]    delay_all [NUM_INPUTS];
  logic [LEVELS_W-1:0]   vis;
  logic [PIN_W-1:0]      emit_idx;
  logic [NUM_INPUTS-1:0] emit_bit;
  logic                  found;
  logic [NUM_INPUTS-1:0] acc_next;

  pin_req_t req;
  pin_res_t res;

  always_comb begin
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (i < GROUP_PINS) begin
        delay_all[i] = delays_low[(i % GROUP_PINS) * DELAY_W +: DELAY_W];
      end else begin
        delay_all[i] = delays_high[(i % GROUP_PINS) * DELAY_W +: DELAY_W];
      end
    end
  end

  always_comb begin
    vis = '0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      vis[i] = stable_level[i] ^ invert;
    end
  end

  always_comb begin
    found    = 1'b0;
    emit_idx = '0;
    emit_bit = '0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (!found && acc_mask[i]) begin
        found       = 1'b1;
        emit_idx    = PIN_W'(i);
        emit_bit[i] = 1'b1;
      end
    end
  end

  always_comb begin
    req.resync = (op_r == OP_RESYNC);
    req.level  = pins_r[pin_ctr];
    req.stable = stable_level[pin_ctr];
    req.known  = level_known[pin_ctr];
    req.enable = enable_mask[pin_ctr];
    req.count  = change_count[pin_ctr];
    req.delay  = delay_all[pin_ctr];
  end

  mld_count_unit u_count (
    .req(req),
    .res(res)
  );

  always_comb begin
    acc_next          = acc_mask;
    acc_next[pin_ctr] = res.accept;
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      delays_low  <= '0;
      delays_high <= '0;
      enable_mask <= ENABLE_RESET;
      invert      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DELAYS_LOW:  delays_low  <= cfg_wdata[GROUP_W-1:0];
        CFG_DELAYS_HIGH: delays_high <= cfg_wdata[GROUP_W-1:0];
        CFG_ENABLE_MASK: enable_mask <= cfg_wdata[LEVELS_W-1:0];
        CFG_INVERT:      invert      <= cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      pin_ctr      <= '0;
      acc_mask     <= '0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
        stable_level[i] <= 1'b0;
        level_known[i]  <= 1'b0;
        change_count[i] <= '0;
      end
    end else begin
      // in S_EMIT a taken item is always replaced by the next report
      if (out_ch.valid && out_ch.ready && (state != S_EMIT)) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r     <= in_ch.op;
            pins_r   <= in_ch.pin_levels;
            pin_ctr  <= '0;
            acc_mask <= '0;
            state    <= S_PROC;
          end
        end
        S_PROC: begin
          change_count[pin_ctr] <= res.count;
          acc_mask              <= acc_next;
          if (res.accept) begin
            stable_level[pin_ctr] <= req.level;
            level_known[pin_ctr]  <= 1'b1;
          end
          if (pin_ctr == PIN_W'(NUM_INPUTS - 1)) begin
            state <= (acc_next != '0) ? S_EMIT : S_IDLE;
          end else begin
            pin_ctr <= pin_ctr + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid          <= 1'b1;
            out_ch.input_index    <= IDX_W'(emit_idx);
            out_ch.reported_level <= stable_level[emit_idx] ^ invert;
            out_ch.stable_levels  <= vis;
            out_ch.last_report    <= ((acc_mask & ~emit_bit) == '0);
            acc_mask              <= acc_mask & ~emit_bit;
            if ((acc_mask & ~emit_bit) == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/mld_checker.sv
module mld_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mld_pkg::IDX_W-1:0]    out_index,
  input logic                         out_level,
  input logic [mld_pkg::LEVELS_W-1:0] out_levels,
  input logic                         out_last
);
  import mld_pkg::*;

  // busy right after an item is taken (the design stays busy for the whole pin walk)
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready high right after an accepted input item");

  // no new item while reports of the current one are still coming
  a_no_input_mid_reports: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last && !out_ready) |=> !in_ready)
    else $error("input ready while reports are pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index) &&
      $stable(out_level) && $stable(out_levels) && $stable(out_last)))
    else $error("stalled output item changed");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind multi_input_leaky_debouncer mld_checker u_mld_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.input_index),
  .out_level (out_ch.reported_level),
  .out_levels(out_ch.stable_levels),
  .out_last  (out_ch.last_report)
);
